@@ rtl/erhf_pkg.sv @@
// Shared types, codes and constants for the Ethernet receive header filter.
package erhf_pkg;

  localparam int MAC_W      = 48;
  localparam int ETYPE_W    = 16;
  localparam int LEN_W      = 14;
  localparam int IDX_W      = 3;
  localparam int CODE_W     = 3;
  localparam int VALUE_W    = 64;
  localparam int N_COUNTERS = 7;
  localparam int GROUP_BIT  = 40;

  // opcodes
  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // statistics counter indexes
  localparam logic [IDX_W-1:0] CNT_FRAMES  = 3'd0;
  localparam logic [IDX_W-1:0] CNT_BYTES   = 3'd1;
  localparam logic [IDX_W-1:0] CNT_ERRORS  = 3'd2;
  localparam logic [IDX_W-1:0] CNT_DROPPED = 3'd3;
  localparam logic [IDX_W-1:0] CNT_MCAST   = 3'd4;
  localparam logic [IDX_W-1:0] CNT_IPV6    = 3'd5;
  localparam logic [IDX_W-1:0] CNT_VLAN    = 3'd6;

  // verdict codes
  localparam logic [CODE_W-1:0] VERD_ACCEPT     = 3'd0;
  localparam logic [CODE_W-1:0] VERD_NOT_FOR_US = 3'd1;
  localparam logic [CODE_W-1:0] VERD_UNKNOWN    = 3'd2;
  localparam logic [CODE_W-1:0] VERD_SHORT      = 3'd3;
  localparam logic [CODE_W-1:0] VERD_BAD_DEST   = 3'd4;
  localparam logic [CODE_W-1:0] VERD_BAD_SRC    = 3'd5;

  // protocol classes
  localparam logic [CODE_W-1:0] CLASS_IPV4 = 3'd0;
  localparam logic [CODE_W-1:0] CLASS_ARP  = 3'd1;
  localparam logic [CODE_W-1:0] CLASS_IPV6 = 3'd2;
  localparam logic [CODE_W-1:0] CLASS_VLAN = 3'd3;
  localparam logic [CODE_W-1:0] CLASS_NONE = 3'd4;

  // ether types
  localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [ETYPE_W-1:0] ETYPE_ARP  = 16'h0806;
  localparam logic [ETYPE_W-1:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [ETYPE_W-1:0] ETYPE_VLAN = 16'h8100;

  localparam logic [LEN_W-1:0] HDR_LEN = 14'd14;

  typedef struct packed {
    logic               opcode;
    logic [MAC_W-1:0]   dest_mac;
    logic [MAC_W-1:0]   src_mac;
    logic [ETYPE_W-1:0] ether_type;
    logic [LEN_W-1:0]   frame_len;
    logic [IDX_W-1:0]   counter_index;
  } hdr_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  verdict;
    logic [CODE_W-1:0]  protocol_class;
    logic               group_address;
    logic [VALUE_W-1:0] counter_value;
  } res_item_t;

  // counter bumps for one frame; bytes moves with frames
  typedef struct packed {
    logic frames;
    logic errors;
    logic dropped;
    logic mcast;
    logic ipv6;
    logic vlan;
  } cnt_inc_t;

endpackage

@@ rtl/erhf_chan_if.sv @@
// Valid/ready channel carrying one item of a given payload type.
interface erhf_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ethernet_rx_header_filter.sv @@
// Top level of the Ethernet receive header filter with statistics counters.
//
//   channel  dir  payload                                              handshake
//   cfg      in   own_mac (48 bits)                                    valid/ready
//   hdr      in   opcode, dest_mac, src_mac, ether_type, frame_len,    valid/ready
//                 counter_index
//   res      out  verdict, protocol_class, group_address,              valid/ready
//                 counter_value
//
// One item per cycle sustained while res.ready holds. hdr lands in an input
// register; the filter decision, counter update and counter read happen as it
// moves into the result register. Counters update in item order, so a read
// sees every earlier frame. Synchronous reset clears counters, own_mac and
// the valid flags. A stalled result holds its register; the input register
// still takes an item whenever the result register can drain.
module ethernet_rx_header_filter import erhf_pkg::*; #(
  parameter int COUNTER_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  erhf_chan_if.sink   cfg,
  erhf_chan_if.sink   hdr,
  erhf_chan_if.source res
);

  // configuration: always ready; the user must write it only while idle, the block does not enforce this
  logic [MAC_W-1:0] own_mac;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
    end else if (cfg.valid) begin
      own_mac <= MAC_W'(cfg.data);
    end
  end

  // input register
  logic      s1_valid;
  hdr_item_t s1_item;
  logic      out_free;
  logic      s1_fire;
  logic      in_fire;

  // result register
  logic      out_valid;
  res_item_t out_item;

  assign out_free  = !out_valid || res.ready;
  assign s1_fire   = s1_valid && out_free;
  assign hdr.ready = !s1_valid || out_free;
  assign in_fire   = hdr.valid && hdr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= hdr.data;
    end
  end

  // decision on the held item
  logic [CODE_W-1:0]  verdict;
  logic [CODE_W-1:0]  protocol_class;
  logic               group_address;
  cnt_inc_t           inc;
  logic [VALUE_W-1:0] rd_value;

  erhf_classify u_classify (
    .hdr            (s1_item),
    .own_mac        (own_mac),
    .verdict        (verdict),
    .protocol_class (protocol_class),
    .group_address  (group_address),
    .inc            (inc)
  );

  // counters bump as the item leaves the input register
  erhf_counters #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_counters (
    .clk       (clk),
    .rst       (rst),
    .upd_en    (s1_fire),
    .inc       (inc),
    .frame_len (s1_item.frame_len),
    .rd_index  (s1_item.counter_index),
    .rd_value  (rd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item.verdict        <= verdict;
      out_item.protocol_class <= protocol_class;
      out_item.group_address  <= group_address;
      // value only for reads
      out_item.counter_value  <= (s1_item.opcode == OP_READ) ? rd_value : '0;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_item;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |-> !in_fire)
    else $error("input register overwritten while held");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire))
    else $error("result appeared without an item leaving the input register");

endmodule

@@ rtl/erhf_classify.sv @@
// Header checks, destination filter and ether type classification.
module erhf_classify import erhf_pkg::*; (
  input  hdr_item_t          hdr,
  input  logic [MAC_W-1:0]   own_mac,
  output logic [CODE_W-1:0]  verdict,
  output logic [CODE_W-1:0]  protocol_class,
  output logic               group_address,
  output cnt_inc_t           inc
);

  logic is_group;

  assign is_group = hdr.dest_mac[GROUP_BIT];

  always_comb begin
    verdict        = VERD_ACCEPT;
    protocol_class = CLASS_NONE;
    group_address  = 1'b0;
    inc            = '0;
    if (hdr.opcode == OP_PROCESS) begin
      if (hdr.frame_len < HDR_LEN) begin
        inc.errors = 1'b1;
        verdict    = VERD_SHORT;
      end else if (hdr.dest_mac == '0) begin
        inc.errors = 1'b1;
        verdict    = VERD_BAD_DEST;
      end else if (hdr.src_mac == '0 || hdr.src_mac[GROUP_BIT]) begin
        inc.errors = 1'b1;
        verdict    = VERD_BAD_SRC;
      end else begin
        group_address = is_group;
        inc.mcast     = is_group;
        if (!is_group && hdr.dest_mac != own_mac) begin
          inc.dropped = 1'b1;
          verdict     = VERD_NOT_FOR_US;
        end else begin
          inc.frames = 1'b1;
          case (hdr.ether_type)
            ETYPE_IPV4: protocol_class = CLASS_IPV4;
            ETYPE_ARP:  protocol_class = CLASS_ARP;
            ETYPE_IPV6: begin
              protocol_class = CLASS_IPV6;
              inc.ipv6       = 1'b1;
            end
            ETYPE_VLAN: begin
              protocol_class = CLASS_VLAN;
              inc.vlan       = 1'b1;
            end
            default: begin
              inc.dropped = 1'b1;
              verdict     = VERD_UNKNOWN;
            end
          endcase
        end
      end
    end
  end

endmodule

@@ rtl/erhf_counters.sv @@
// Bank of seven wrapping statistics counters with one read port.
module erhf_counters import erhf_pkg::*; #(
  parameter int COUNTER_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               upd_en,
  input  cnt_inc_t           inc,
  input  logic [LEN_W-1:0]   frame_len,
  input  logic [IDX_W-1:0]   rd_index,
  output logic [VALUE_W-1:0] rd_value
);

  logic [COUNTER_WIDTH-1:0] cnt [N_COUNTERS];
  logic [N_COUNTERS-1:0]    bump;

  always_comb begin
    bump              = '0;
    bump[CNT_FRAMES]  = inc.frames;
    bump[CNT_BYTES]   = inc.frames;
    bump[CNT_ERRORS]  = inc.errors;
    bump[CNT_DROPPED] = inc.dropped;
    bump[CNT_MCAST]   = inc.mcast;
    bump[CNT_IPV6]    = inc.ipv6;
    bump[CNT_VLAN]    = inc.vlan;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N_COUNTERS; i++) begin
        cnt[i] <= '0;
      end
    end else if (upd_en) begin
      for (int i = 0; i < N_COUNTERS; i++) begin
        if (bump[i]) begin
          if (i == int'(CNT_BYTES)) begin
            cnt[i] <= cnt[i] + COUNTER_WIDTH'(frame_len);
          end else begin
            cnt[i] <= cnt[i] + COUNTER_WIDTH'(1);
          end
        end
      end
    end
  end

  // index 7 reads as zero
  always_comb begin
    rd_value = '0;
    if (int'(rd_index) < N_COUNTERS) begin
      rd_value = VALUE_W'(cnt[rd_index]);
    end
  end

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !upd_en |=> ($stable(cnt[CNT_FRAMES]) && $stable(cnt[CNT_ERRORS])
                 && $stable(cnt[CNT_DROPPED])))
    else $error("counters moved without an update");

  a_err_exclusive: assert property (@(posedge clk) disable iff (rst)
    (upd_en && inc.errors) |-> !(inc.frames || inc.dropped || inc.mcast))
    else $error("error frame also counted as received");

  a_type_needs_frame: assert property (@(posedge clk) disable iff (rst)
    (upd_en && (inc.ipv6 || inc.vlan)) |-> inc.frames)
    else $error("type counter bumped without frame count");

endmodule
